// ===== rtl/core/imu_fc_pkg.sv =====
// imu_fc_pkg: shared types and constants of the imu frame conditioner
// used by imu_fc_div and imu_frame_conditioner; no dependencies
package imu_fc_pkg;

   // filter and health constants
   localparam int ALPHA_FRAC_BITS = 8;
   localparam int ALPHA_ONE       = 1 << ALPHA_FRAC_BITS;
   localparam int FAIL_LIMIT      = 10;
   localparam int FAIL_MAX        = 15;

   // scaling constants
   localparam int ACC_DIV_MIN = 2048;
   localparam int GYR_DIV_MIN = 16;
   localparam int ACC_SCALE   = 1000;
   localparam int GYR_SCALE   = 100;
   localparam int TEMP_DIV    = 340;
   localparam int TEMP_OFFSET = 3653;

   // reciprocal of TEMP_DIV: ceil(2^31 / 340), exact for magnitudes below 2^23
   localparam int TEMP_RCP    = 6316129;
   localparam int TEMP_RCP_SH = 31;

   // shared multiplier and divider widths
   localparam int MUL_B_W = (ALPHA_FRAC_BITS + 2 > 12) ? ALPHA_FRAC_BITS + 2 : 12;
   localparam int MUL_P_W = 16 + MUL_B_W;
   localparam int ACC_W   = MUL_P_W + 1;
   localparam int DIV_W   = 27;
   localparam int DVS_W   = 15;

   // command codes
   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_FAIL    = 2'd1;
   localparam logic [1:0] CMD_CALIB   = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   // register indexes
   localparam logic [1:0] REG_ACC_SENS = 2'd0;
   localparam logic [1:0] REG_GYR_SENS = 2'd1;
   localparam logic [1:0] REG_ALPHA    = 2'd2;
   localparam logic [1:0] REG_CAL_N    = 2'd3;

   // divider request
   typedef struct packed {
      logic                    start;
      logic signed [DIV_W-1:0] dividend;
      logic [DVS_W-1:0]        divisor;
   } div_req_type;

endpackage

// ===== rtl/core/imu_fc_div.sv =====
// imu_fc_div: shared signed-by-positive divider, one quotient bit per cycle
// depends on imu_fc_pkg
module imu_fc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  imu_fc_pkg::div_req_type           req,
   output logic                              done,
   output logic signed [imu_fc_pkg::DIV_W-1:0] quotient
);
   import imu_fc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;
   logic [DIV_W-1:0] mag;

   // restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
      mag   = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req.start) begin
         cnt_ff <= CNT_W'(DIV_W);
         quo_ff <= mag;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
         neg_ff <= req.dividend[DIV_W-1];
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

// ===== rtl/core/imu_frame_conditioner.sv =====
// channel  | dir | ports               | content
// req      | in  | req_t*              | tuser command, tdata raw frame
// rsp      | out | rsp_t*              | tuser status flags, tdata cached values
// csr      | in  | csr_p*              | four configuration registers
//
// a data frame runs the filter on the shared multiplier, then 6 axis scalings
// on the 27-step divider and the temperature, which uses a reciprocal
// multiply; a seeding frame skips the filter; a completing calibration frame
// runs three bias divisions, other commands go straight to the output
// one request at a time; req_tready is high only while idle
// a result waits in the output register while the next request is taken
// imu_frame_conditioner: top level; depends on imu_fc_pkg and imu_fc_div
module imu_frame_conditioner (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // acc_x, acc_y, acc_z, temp_raw, gyro_x, gyro_y, gyro_z (16 b each)
   input  logic [111:0] req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // accel_x_mg, accel_y_mg, accel_z_mg (15 b), rate_x/y/z_cdps (19 b),
   // temp_centi_c (15 b), zero pad (3 b)
   output logic [119:0] rsp_tdata,
   // healthy, updated, calib_done
   output logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import imu_fc_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EMA_X    = 4'd1;
   localparam logic [3:0] S_EMA_P    = 4'd2;
   localparam logic [3:0] S_EMA_ADD  = 4'd3;
   localparam logic [3:0] S_EMA_WR   = 4'd4;
   localparam logic [3:0] S_PRIME    = 4'd5;
   localparam logic [3:0] S_SC_MUL   = 4'd6;
   localparam logic [3:0] S_SC_GO    = 4'd7;
   localparam logic [3:0] S_SC_WAIT  = 4'd8;
   localparam logic [3:0] S_CAL_GO   = 4'd9;
   localparam logic [3:0] S_CAL_WAIT = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   // configuration registers
   logic [14:0] acc_sens_ff;
   logic [7:0]  gyr_sens_ff;
   logic [8:0]  alpha_ff;
   logic [7:0]  cal_n_ff;

   // block state
   logic [3:0]               state_ff;
   logic [2:0]               idx_ff;
   logic signed [15:0]       work_ff [7];
   logic signed [15:0]       prev_ff [6];
   logic signed [15:0]       bias_ff [3];
   logic signed [23:0]       sum_ff [3];
   logic [7:0]               count_ff;
   logic [7:0]               cal_div_ff;
   logic                     primed_ff;
   logic [3:0]               fail_ff;
   logic                     healthy_ff;
   logic                     upd_ff;
   logic                     done_ff;
   logic signed [18:0]       cache_ff [7];
   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     rsp_valid_ff;
   logic [119:0]             rsp_data_ff;
   logic [2:0]               rsp_user_ff;

   logic                     accept;
   logic                     cfg_write;
   logic [MUL_B_W-1:0]       alpha_ext;
   logic [MUL_B_W-1:0]       alpha_sat;
   logic signed [15:0]       mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] product;
   logic signed [ACC_W-1:0]  acc_round;
   logic signed [ACC_W-1:0]  acc_shift;
   logic [14:0]              acc_div;
   logic [7:0]               gyr_div;
   logic [8:0]               count_next;
   logic [3:0]               fail_next;
   div_req_type              div_req;
   logic                     div_done;
   logic signed [DIV_W-1:0]  div_q;
   logic [21:0]              temp_mag;
   logic [44:0]              temp_prod;
   logic [13:0]              temp_quo;
   logic signed [18:0]       temp_val;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_sens_ff <= 15'd16384;
         gyr_sens_ff <= 8'd131;
         alpha_ff    <= 9'd77;
         cal_n_ff    <= 8'd200;
      end else if (cfg_write) begin
         unique case (csr_paddr[3:2])
            REG_ACC_SENS: acc_sens_ff <= csr_pwdata[14:0];
            REG_GYR_SENS: gyr_sens_ff <= csr_pwdata[7:0];
            REG_ALPHA:    alpha_ff    <= csr_pwdata[8:0];
            REG_CAL_N:    cal_n_ff    <= csr_pwdata[7:0];
            default:      ;
         endcase
      end
   end

   // configuration read
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ACC_SENS: csr_prdata = {17'd0, acc_sens_ff};
         REG_GYR_SENS: csr_prdata = {24'd0, gyr_sens_ff};
         REG_ALPHA:    csr_prdata = {23'd0, alpha_ff};
         REG_CAL_N:    csr_prdata = {24'd0, cal_n_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // clamped weights and divisors
   always_comb begin
      alpha_ext = {{(MUL_B_W-9){1'b0}}, alpha_ff};
      alpha_sat = (alpha_ext > MUL_B_W'(ALPHA_ONE)) ? MUL_B_W'(ALPHA_ONE) : alpha_ext;
      acc_div   = (acc_sens_ff < 15'(ACC_DIV_MIN)) ? 15'(ACC_DIV_MIN) : acc_sens_ff;
      gyr_div   = (gyr_sens_ff < 8'(GYR_DIV_MIN)) ? 8'(GYR_DIV_MIN) : gyr_sens_ff;
   end

   // shared multiplier operand select
   always_comb begin
      if (state_ff == S_EMA_X) begin
         mul_a = work_ff[idx_ff];
         mul_b = $signed(alpha_sat);
      end else if (state_ff == S_EMA_P) begin
         mul_a = prev_ff[(idx_ff < 3'd6) ? idx_ff : 3'd0];
         mul_b = $signed(MUL_B_W'(ALPHA_ONE) - alpha_sat);
      end else begin
         mul_a = work_ff[idx_ff];
         mul_b = (idx_ff < 3'd3) ? MUL_B_W'(ACC_SCALE) : MUL_B_W'(GYR_SCALE);
      end
      product = mul_a * mul_b;
   end

   // filter truncation toward zero
   always_comb begin
      acc_round = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'(ALPHA_ONE - 1) : ACC_W'(0));
      acc_shift = acc_round >>> ALPHA_FRAC_BITS;
   end

   // temperature: scaled count over 340 by reciprocal multiply, toward zero
   always_comb begin
      temp_mag  = prod_ff[MUL_P_W-1] ? 22'(-prod_ff) : 22'(prod_ff);
      temp_prod = {23'd0, temp_mag} * 45'(TEMP_RCP);
      temp_quo  = temp_prod[TEMP_RCP_SH +: 14];
      temp_val  = (prod_ff[MUL_P_W-1] ? -19'(temp_quo) : 19'(temp_quo))
                  + 19'(TEMP_OFFSET);
   end

   // divider request
   always_comb begin
      div_req.start    = ((state_ff == S_SC_GO) && (idx_ff != 3'd6)) ||
                         (state_ff == S_CAL_GO);
      div_req.dividend = prod_ff[DIV_W-1:0];
      if (idx_ff < 3'd3) begin
         div_req.divisor = acc_div;
      end else begin
         div_req.divisor = {7'd0, gyr_div};
      end
      if (state_ff == S_CAL_GO) begin
         div_req.dividend = DIV_W'(sum_ff[(idx_ff < 3'd3) ? idx_ff[1:0] : 2'd0]);
         div_req.divisor  = {7'd0, cal_div_ff};
      end
   end

   imu_fc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign count_next = {1'b0, count_ff} + 9'd1;
   assign fail_next  = (fail_ff < 4'(FAIL_MAX)) ? fail_ff + 4'd1 : fail_ff;

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         primed_ff    <= 1'b0;
         fail_ff      <= '0;
         healthy_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         upd_ff       <= 1'b0;
         done_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            bias_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
         for (int i = 0; i < 7; i++) begin
            cache_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  upd_ff  <= 1'b0;
                  done_ff <= 1'b0;
                  idx_ff  <= '0;
                  state_ff <= S_OUT;
                  case (req_tuser)
                     CMD_DATA: begin
                        fail_ff  <= '0;
                        upd_ff   <= 1'b1;
                        state_ff <= primed_ff ? S_EMA_X : S_PRIME;
                     end
                     CMD_FAIL: begin
                        fail_ff <= fail_next;
                        if (fail_next >= 4'(FAIL_LIMIT)) begin
                           healthy_ff <= 1'b0;
                        end
                     end
                     CMD_CALIB: begin
                        for (int i = 0; i < 3; i++) begin
                           sum_ff[i] <= sum_ff[i] + 24'(signed'(req_tdata[64+16*i +: 16]));
                        end
                        if (count_next >= {1'b0, cal_n_ff}) begin
                           cal_div_ff <= count_next[7:0];
                           count_ff   <= '0;
                           state_ff   <= S_CAL_GO;
                        end else begin
                           count_ff <= count_next[7:0];
                        end
                     end
                     default: begin
                        healthy_ff <= 1'b1;
                        fail_ff    <= '0;
                        primed_ff  <= 1'b0;
                        count_ff   <= '0;
                        for (int i = 0; i < 3; i++) begin
                           sum_ff[i] <= '0;
                        end
                     end
                  endcase
               end
            end
            S_EMA_X: begin
               prod_ff  <= product;
               state_ff <= S_EMA_P;
            end
            S_EMA_P: begin
               acc_ff   <= ACC_W'(prod_ff);
               prod_ff  <= product;
               state_ff <= S_EMA_ADD;
            end
            S_EMA_ADD: begin
               acc_ff   <= acc_ff + ACC_W'(prod_ff);
               state_ff <= S_EMA_WR;
            end
            S_EMA_WR: begin
               if (idx_ff == 3'd5) begin
                  idx_ff   <= '0;
                  state_ff <= S_PRIME;
               end else begin
                  idx_ff   <= idx_ff + 3'd1;
                  state_ff <= S_EMA_X;
               end
            end
            S_PRIME: begin
               primed_ff <= 1'b1;
               state_ff  <= S_SC_MUL;
            end
            S_SC_MUL: begin
               prod_ff  <= product;
               state_ff <= S_SC_GO;
            end
            S_SC_GO: begin
               if (idx_ff == 3'd6) begin
                  cache_ff[6] <= temp_val;
                  state_ff    <= S_OUT;
               end else begin
                  state_ff <= S_SC_WAIT;
               end
            end
            S_SC_WAIT: begin
               if (div_done) begin
                  cache_ff[idx_ff] <= div_q[18:0];
                  idx_ff   <= idx_ff + 3'd1;
                  state_ff <= S_SC_MUL;
               end
            end
            S_CAL_GO: begin
               state_ff <= S_CAL_WAIT;
            end
            S_CAL_WAIT: begin
               if (div_done) begin
                  bias_ff[idx_ff[1:0]] <= div_q[15:0];
                  sum_ff[idx_ff[1:0]]  <= '0;
                  if (idx_ff == 3'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     idx_ff   <= idx_ff + 3'd1;
                     state_ff <= S_CAL_GO;
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // working values and filter memory
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            work_ff[i]     <= req_tdata[16*i +: 16];
            work_ff[3 + i] <= $signed(req_tdata[64+16*i +: 16]) - bias_ff[i];
         end
         work_ff[6] <= req_tdata[63:48];
      end else if (state_ff == S_EMA_WR) begin
         work_ff[idx_ff] <= acc_shift[15:0];
      end
      if (state_ff == S_PRIME) begin
         for (int i = 0; i < 6; i++) begin
            prev_ff[i] <= work_ff[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {3'd0, cache_ff[6][14:0],
                         cache_ff[5], cache_ff[4], cache_ff[3],
                         cache_ff[2][14:0], cache_ff[1][14:0], cache_ff[0][14:0]};
         rsp_user_ff <= {done_ff, upd_ff, healthy_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== verif/imu_frame_conditioner_checker.sv =====
// imu_frame_conditioner_checker: watches the request and result channels,
// predicts each result and compares it; depends on imu_fc_pkg
module imu_frame_conditioner_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [119:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output int           fail_count,
   output int           pending,
   output int           frames_seen,
   output int           calibs_seen
);
   import imu_fc_pkg::*;

   typedef struct packed {
      logic [2:0]   flags;
      logic [119:0] values;
   } frame_result_type;

   // conditioner state mirror
   logic [14:0] acc_sens;
   logic [7:0]  gyr_sens;
   logic [8:0]  alpha;
   logic [7:0]  cal_n;
   int          bias [3];
   int          cal_sum [3];
   int          cal_cnt;
   int          prev [6];
   bit          primed;
   int          fails;
   bit          healthy;
   int          cache [7];

   frame_result_type expected_results[$];

   function automatic int smooth(int x, int p, longint a);
      longint s;
      s = a * x + (ALPHA_ONE - a) * p;
      return int'(s / ALPHA_ONE);
   endfunction

   // advance the mirror by one request and queue the result
   task automatic condition_frame(logic [1:0] cmd, logic [111:0] d);
      int     v [6];
      longint a;
      int     adiv, gdiv;
      bit     upd, done;
      frame_result_type r;
      upd = 0;
      done = 0;
      case (cmd)
         CMD_DATA: begin
            a = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
            adiv = (acc_sens < ACC_DIV_MIN) ? ACC_DIV_MIN : acc_sens;
            gdiv = (gyr_sens < GYR_DIV_MIN) ? GYR_DIV_MIN : gyr_sens;
            fails = 0;
            for (int i = 0; i < 3; i++) begin
               v[i] = int'($signed(d[16*i +: 16]));
               v[3+i] = int'($signed(16'(int'($signed(d[64+16*i +: 16])) - bias[i])));
            end
            if (primed)
               for (int i = 0; i < 6; i++) v[i] = smooth(v[i], prev[i], a);
            for (int i = 0; i < 6; i++) prev[i] = v[i];
            primed = 1;
            for (int i = 0; i < 3; i++) begin
               cache[i] = v[i] * ACC_SCALE / adiv;
               cache[3+i] = v[3+i] * GYR_SCALE / gdiv;
            end
            cache[6] = int'($signed(d[48 +: 16])) * GYR_SCALE / TEMP_DIV + TEMP_OFFSET;
            upd = 1;
         end
         CMD_FAIL: begin
            if (fails < FAIL_MAX) fails++;
            if (fails >= FAIL_LIMIT) healthy = 0;
         end
         CMD_CALIB: begin
            for (int i = 0; i < 3; i++) cal_sum[i] += int'($signed(d[64+16*i +: 16]));
            cal_cnt++;
            if (cal_cnt >= cal_n) begin
               for (int i = 0; i < 3; i++) begin
                  bias[i] = cal_sum[i] / cal_cnt;
                  cal_sum[i] = 0;
               end
               cal_cnt = 0;
               done = 1;
            end
         end
         default: begin
            healthy = 1;
            fails = 0;
            primed = 0;
            for (int i = 0; i < 3; i++) cal_sum[i] = 0;
            cal_cnt = 0;
         end
      endcase
      r.values = {3'b0, 15'(cache[6]), 19'(cache[5]), 19'(cache[4]), 19'(cache[3]),
                  15'(cache[2]), 15'(cache[1]), 15'(cache[0])};
      r.flags = {done, upd, healthy};
      expected_results.push_back(r);
      if (upd) frames_seen++;
      if (done) calibs_seen++;
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         acc_sens = 15'd16384;
         gyr_sens = 8'd131;
         alpha = 9'd77;
         cal_n = 8'd200;
         for (int i = 0; i < 3; i++) begin
            bias[i] = 0;
            cal_sum[i] = 0;
         end
         for (int i = 0; i < 6; i++) prev[i] = 0;
         for (int i = 0; i < 7; i++) cache[i] = 0;
         cal_cnt = 0;
         primed = 0;
         fails = 0;
         healthy = 0;
         expected_results.delete();
         fail_count = 0;
         frames_seen = 0;
         calibs_seen = 0;
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite)
            case (csr_paddr[3:2])
               REG_ACC_SENS: acc_sens = csr_pwdata[14:0];
               REG_GYR_SENS: gyr_sens = csr_pwdata[7:0];
               REG_ALPHA:    alpha = csr_pwdata[8:0];
               default:      cal_n = csr_pwdata[7:0];
            endcase
         // result compare
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result tuser %h tdata %h", $time,
                        rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (want.values !== rsp_tdata || want.flags !== rsp_tuser) begin
                  $display("%0t: mismatch expected tuser %h tdata %h", $time,
                           want.flags, want.values);
                  $display("%0t:          actual   tuser %h tdata %h", $time,
                           rsp_tuser, rsp_tdata);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) condition_frame(req_tuser, req_tdata);
      end
      pending = expected_results.size();
   end

endmodule

// ===== verif/imu_frame_conditioner_tb.sv =====
// imu_frame_conditioner_tb: drives requests, register writes and stalls into
// the conditioner; depends on imu_fc_pkg, imu_frame_conditioner and its checker
module imu_frame_conditioner_tb;
   import imu_fc_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int errors, pending, frames_seen, calibs_seen;
   int send_idle, recv_stall;
   int cycles;
   int cal_target;

   imu_frame_conditioner uut (.*);

   imu_frame_conditioner_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(errors), .pending(pending),
      .frames_seen(frames_seen), .calibs_seen(calibs_seen));

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 3000000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall);

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // stop sending, wait out all results, then the longest in-flight work
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // valid stays up after the accepting edge until the next request or idle
   task automatic send(logic [1:0] cmd, logic [111:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [111:0] rand_frame();
      logic [111:0] d;
      for (int i = 0; i < 7; i++)
         case ($urandom_range(5))
            0: d[16*i +: 16] = 16'h8000;
            1: d[16*i +: 16] = 16'h7fff;
            2: d[16*i +: 16] = 16'($signed($urandom_range(400)) - 200);
            default: d[16*i +: 16] = 16'($urandom);
         endcase
      return d;
   endfunction

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = CMD_DATA;
      rsp_tready = 1;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle = 0;
      recv_stall = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, extremes, seeding, calibration, failures
      send(CMD_DATA, {7{16'h7fff}});
      send(CMD_RESTART, '0);
      send(CMD_DATA, {7{16'h8000}});
      send(CMD_DATA, {7{16'h7fff}});
      send(CMD_DATA, '0);
      for (int i = 0; i < 12; i++) send(CMD_FAIL, rand_frame());
      send(CMD_DATA, {7{16'hffff}});
      drain();
      write_reg(REG_CAL_N, 3);
      write_reg(REG_ALPHA, 256);
      send(CMD_CALIB, {16'h7fff, 16'h8000, 16'h0005, 64'h0});
      send(CMD_CALIB, {16'h7fff, 16'h8000, 16'hfff9, 64'h0});
      send(CMD_CALIB, {16'h7fff, 16'h8000, 16'h0001, 64'h0});
      send(CMD_DATA, {16'h8000, 16'h7fff, 16'h0000, 16'h8000, 48'h0});
      drain();
      write_reg(REG_ACC_SENS, 32'h7fff);
      write_reg(REG_GYR_SENS, 255);
      write_reg(REG_ALPHA, 511);
      write_reg(REG_CAL_N, 0);
      send(CMD_CALIB, rand_frame());
      send(CMD_DATA, {7{16'h8000}});
      send(CMD_DATA, {7{16'h7fff}});
      drain();

      // random phases with different settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 66; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 66; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         case (ph)
            0: begin
               write_reg(REG_ACC_SENS, 2048); write_reg(REG_GYR_SENS, 16);
               write_reg(REG_ALPHA, 0); write_reg(REG_CAL_N, 1);
            end
            1: begin
               write_reg(REG_ACC_SENS, 0); write_reg(REG_GYR_SENS, 0);
               write_reg(REG_ALPHA, 77); write_reg(REG_CAL_N, 255);
            end
            default: begin
               write_reg(REG_ACC_SENS, $urandom_range(32767));
               write_reg(REG_GYR_SENS, $urandom_range(255));
               write_reg(REG_ALPHA, $urandom_range(511));
               write_reg(REG_CAL_N, $urandom_range(1, 12));
            end
         endcase
         for (int n = 0; n < 135; n++) begin
            int k;
            k = $urandom_range(99);
            if (k < 55) send(CMD_DATA, rand_frame());
            else if (k < 75) send(CMD_CALIB, rand_frame());
            else if (k < 92) send(CMD_FAIL, rand_frame());
            else send(CMD_RESTART, rand_frame());
         end
         drain();
      end

      $display("covered %0d data frames and %0d completed calibrations", frames_seen,
               calibs_seen);
      $display("over eight register settings with sender and receiver stalls");
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== imu_frame_conditioner.f =====
rtl/core/imu_fc_pkg.sv
rtl/core/imu_fc_div.sv
rtl/core/imu_frame_conditioner.sv
verif/imu_frame_conditioner_checker.sv
verif/imu_frame_conditioner_tb.sv
